@@ rtl/u8d_pkg.sv @@
// shared constants for the utf-8 stream decoder
package u8d_pkg;

   localparam int unsigned CP_W   = 21;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CNT_W  = 2;

   // replacement character '?'
   localparam logic [CP_W-1:0] REPL_CP = 21'd63;

   // lead byte payload masks
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

   // continuation bytes still expected after each lead form
   localparam logic [CNT_W-1:0] NEED_LEAD2 = 2'd1;
   localparam logic [CNT_W-1:0] NEED_LEAD3 = 2'd2;
   localparam logic [CNT_W-1:0] NEED_LEAD4 = 2'd3;

endpackage

@@ rtl/utf8_stream_decoder.sv @@
// utf-8 stream decoder top level: byte decode and result run sequencer
//
//   channel | direction | ports                                     | handshake
//   req     | in        | req_text_byte                             | req_valid / req_stall
//   rsp     | out       | rsp_code_point, rsp_text_end, rsp_run_last | rsp_valid / rsp_stall
//
// a byte is decoded in the cycle it is accepted; its results (0 to 4) are held in a
// run register and delivered one per cycle while rsp_stall is low, so one byte per
// cycle is sustained while each byte gives at most one result and rsp_stall is low.
// the next byte is accepted in the same cycle as the last result of the current run.
// reset (synchronous, active high) clears the pending sequence and the run register.
// rsp_stall holds the run; req_stall rises while a run is still pending.
module utf8_stream_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [u8d_pkg::BYTE_W-1:0]  req_text_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [u8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic                        rsp_text_end,
   output logic                        rsp_run_last
);

   // sequence state
   logic [u8d_pkg::CP_W-1:0]  part_ff,  part_in;
   logic [u8d_pkg::CNT_W-1:0] need_ff,  need_in;
   logic [u8d_pkg::CNT_W-1:0] seen_ff,  seen_in;

   // run register: replacement count then an optional final result
   logic [u8d_pkg::CNT_W-1:0] rep_ff,   rep_in;
   logic                      fin_vld_ff, fin_vld_in;
   logic [u8d_pkg::CP_W-1:0]  fin_cp_ff,  fin_cp_in;
   logic                      fin_end_ff, fin_end_in;

   // decode results for the incoming byte
   logic [u8d_pkg::CNT_W-1:0] dec_rep;
   logic                      dec_fin_vld;
   logic [u8d_pkg::CP_W-1:0]  dec_fin_cp;
   logic                      dec_fin_end;
   logic [u8d_pkg::CP_W-1:0]  cont_val;
   logic                      is_cont;

   logic req_fire;
   logic rsp_fire;

   // output side of the run register
   assign rsp_valid      = (rep_ff != '0) || fin_vld_ff;
   assign rsp_code_point = (rep_ff != '0) ? u8d_pkg::REPL_CP : fin_cp_ff;
   assign rsp_text_end   = (rep_ff == '0) && fin_end_ff;
   assign rsp_run_last   = (rep_ff == '0) ||
                           ((rep_ff == u8d_pkg::CNT_W'(1)) && !fin_vld_ff);

   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = rsp_valid && !(rsp_run_last && !rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   assign is_cont  = (req_text_byte[7:6] == 2'b10);
   assign cont_val = {part_ff[u8d_pkg::CP_W-7:0], req_text_byte[5:0]};

   // byte decode against the pending sequence
   always_comb begin
      dec_rep     = '0;
      dec_fin_vld = 1'b0;
      dec_fin_cp  = '0;
      dec_fin_end = 1'b0;
      part_in     = part_ff;
      need_in     = need_ff;
      seen_in     = seen_ff;
      if ((need_ff != '0) && is_cont) begin
         if (need_ff == u8d_pkg::CNT_W'(1)) begin
            dec_fin_vld = 1'b1;
            dec_fin_cp  = cont_val;
            part_in     = '0;
            need_in     = '0;
            seen_in     = '0;
         end else begin
            part_in = cont_val;
            need_in = need_ff - u8d_pkg::CNT_W'(1);
            seen_in = seen_ff + u8d_pkg::CNT_W'(1);
         end
      end else begin
         // broken sequence flushes its buffered bytes first
         if (need_ff != '0) begin
            dec_rep = seen_ff;
         end
         part_in = '0;
         need_in = '0;
         seen_in = '0;
         case (req_text_byte) inside
            8'h00: begin
               dec_fin_vld = 1'b1;
               dec_fin_end = 1'b1;
            end
            [8'h01:8'h7F]: begin
               dec_fin_vld = 1'b1;
               dec_fin_cp  = u8d_pkg::CP_W'(req_text_byte);
            end
            [8'hC0:8'hDF]: begin
               part_in = u8d_pkg::CP_W'(req_text_byte & u8d_pkg::LEAD2_MASK);
               need_in = u8d_pkg::NEED_LEAD2;
               seen_in = u8d_pkg::CNT_W'(1);
            end
            [8'hE0:8'hEF]: begin
               part_in = u8d_pkg::CP_W'(req_text_byte & u8d_pkg::LEAD3_MASK);
               need_in = u8d_pkg::NEED_LEAD3;
               seen_in = u8d_pkg::CNT_W'(1);
            end
            [8'hF0:8'hF7]: begin
               part_in = u8d_pkg::CP_W'(req_text_byte & u8d_pkg::LEAD4_MASK);
               need_in = u8d_pkg::NEED_LEAD4;
               seen_in = u8d_pkg::CNT_W'(1);
            end
            default: begin
               // stray continuation or invalid lead
               dec_fin_vld = 1'b1;
               dec_fin_cp  = u8d_pkg::REPL_CP;
            end
         endcase
      end
   end

   // run register next value: load on request, step on delivery
   always_comb begin
      rep_in     = rep_ff;
      fin_vld_in = fin_vld_ff;
      fin_cp_in  = fin_cp_ff;
      fin_end_in = fin_end_ff;
      if (req_fire) begin
         rep_in     = dec_rep;
         fin_vld_in = dec_fin_vld;
         fin_cp_in  = dec_fin_cp;
         fin_end_in = dec_fin_end;
      end else if (rsp_fire) begin
         if (rep_ff != '0) begin
            rep_in = rep_ff - u8d_pkg::CNT_W'(1);
         end else begin
            fin_vld_in = 1'b0;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff    <= '0;
         need_ff    <= '0;
         seen_ff    <= '0;
         rep_ff     <= '0;
         fin_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            part_ff <= part_in;
            need_ff <= need_in;
            seen_ff <= seen_in;
         end
         rep_ff     <= rep_in;
         fin_vld_ff <= fin_vld_in;
      end
   end

   // run payload
   always_ff @(posedge clock) begin
      fin_cp_ff  <= fin_cp_in;
      fin_end_ff <= fin_end_in;
   end

`ifndef SYNTHESIS
   a_req_only_at_run_end: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!rsp_valid || (rsp_fire && rsp_run_last)))
      else $error("request accepted while a run is still pending");

   a_pending_has_lead: assert property (@(posedge clock) disable iff (reset)
      (need_ff != '0) |-> (seen_ff != '0))
      else $error("sequence pending with no buffered lead");

   a_seq_length: assert property (@(posedge clock) disable iff (reset)
      (need_ff != '0) |-> ((3'(need_ff) + 3'(seen_ff)) <= 3'd4))
      else $error("sequence length beyond four bytes");

   a_run_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_run_last && !req_fire) |=> !rsp_valid)
      else $error("run register not empty after last result");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_end) |-> (rsp_run_last && (rsp_code_point == '0)))
      else $error("end marker not last or not zero");
`endif

endmodule
